[hdl/thgr_pkg.sv]
// ----------------------------------------------------------------------------
// Touch hold gesture recognizer package
// Shared types, widths and register indexes for the hold recognizer.
// ----------------------------------------------------------------------------
package thgr_pkg;

  localparam int SlotsDefault = 8;

  localparam int SlotW   = 3;
  localparam int CoordW  = 12;
  localparam int TimeW   = 32;
  localparam int HoldW   = 16;
  localparam int StatusW = 2;

  localparam int UserW = 6;
  localparam int DataW = 4 * CoordW + 2 * TimeW;
  localparam int SqW   = 2 * CoordW;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DISTANCE  = 2'd0,
    CFG_MIN_HOLD_TIME = 2'd1,
    CFG_NOTIFY_ENABLE = 2'd2
  } cfg_index_e;

  typedef enum logic [StatusW-1:0] {
    HOLD_NULL = 2'd0,
    HOLD_PROG = 2'd1,
    HOLD_DONE = 2'd2,
    HOLD_FAIL = 2'd3
  } hold_state_e;

endpackage

[hdl/thgr_slot_store.sv]
// ----------------------------------------------------------------------------
// Hold state store
// Per slot hold state in a synchronous memory with a registered read,
// valid bits for reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module thgr_slot_store #(
  parameter int SLOTS = thgr_pkg::SlotsDefault,
  parameter int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output thgr_pkg::hold_state_e rd_state_o,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  thgr_pkg::hold_state_e wr_state_i
);
  import thgr_pkg::*;

  hold_state_e      mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  hold_state_e      rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_state_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // A write landing on the entry being read this cycle is passed straight on.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_q <= wr_state_i;
      end else if (valid_q[rd_idx_i]) begin
        rd_q <= mem_q[rd_idx_i];
      end else begin
        rd_q <= HOLD_NULL;
      end
    end
  end

  assign rd_state_o = rd_q;

endmodule

[hdl/touch_hold_gesture_recognizer.sv]
// ----------------------------------------------------------------------------
// Touch hold gesture recognizer
// Per slot hold recognition on a stream of touch stroke updates.
// ----------------------------------------------------------------------------
// Requests pass the s1, s2 and output registers. Throughput: one request per
// cycle unless the output stalls, set by the single read-modify-write of the
// slot state store per cycle, with forwarding between back to back slots.
// Reset clears the slot valid bits at once, so every slot reads as null; no
// clearing pass is needed. Requests for slots beyond SLOTS give no result.
module touch_hold_gesture_recognizer #(
  parameter int SLOTS = thgr_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [thgr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thgr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot[2:0], is_down[3], stroke_status[5:4]
  input  logic [thgr_pkg::UserW-1:0]    s_axis_tuser,
  // start_x[11:0], start_y[23:12], start_time[55:24], cur_x[67:56],
  // cur_y[79:68], cur_time[111:80]
  input  logic [thgr_pkg::DataW-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_slot[2:0], hold_status[4:3], notify[5]
  output logic [thgr_pkg::UserW-1:0]    m_axis_tuser,
  // out_start_x[11:0], out_start_y[23:12], out_start_time[55:24],
  // out_cur_x[67:56], out_cur_y[79:68], out_cur_time[111:80]
  output logic [thgr_pkg::DataW-1:0]    m_axis_tdata
);
  import thgr_pkg::*;

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [CoordW-1:0] max_dist_q;
  logic [HoldW-1:0]  min_hold_q;
  logic              notify_en_q;
  logic [SqW-1:0]    lim_q;

  logic              s1_valid_q, s2_valid_q, out_valid_q;
  logic              out_ready, s2_ready, s1_ready;
  logic              accept, s1_move, s2_move;

  logic [SlotW-1:0]   s1_slot_q, s2_slot_q;
  logic               s1_down_q, s2_down_q;
  logic [StatusW-1:0] s1_stroke_q, s2_stroke_q;
  logic [DataW-1:0]   s1_data_q, s2_data_q;
  logic [SqW-1:0]     s2_dx2_q, s2_dy2_q;
  logic               s2_hold_ok_q;

  logic [CoordW-1:0] s1_start_x, s1_start_y, s1_cur_x, s1_cur_y;
  logic [TimeW-1:0]  s1_start_time, s1_cur_time, s1_dt;
  logic [CoordW-1:0] s1_adx, s1_ady;

  hold_state_e       cur_state, nxt_state, stroke;
  logic              call;
  logic [SqW:0]      d2;
  logic              too_far;

  logic [UserW-1:0]  out_user_q;
  logic [DataW-1:0]  out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= '0;
      min_hold_q  <= '0;
      notify_en_q <= 1'b0;
      lim_q       <= '0;
    end else begin
      lim_q <= max_dist_q * max_dist_q;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAX_DISTANCE:  max_dist_q  <= cfg_data_i[CoordW-1:0];
          CFG_MIN_HOLD_TIME: min_hold_q  <= cfg_data_i[HoldW-1:0];
          CFG_NOTIFY_ENABLE: notify_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || out_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s1_ready;
  assign s1_move       = s1_valid_q && s2_ready;
  assign s2_move       = s2_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= accept && (32'(s_axis_tuser[SlotW-1:0]) < SLOTS);
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_slot_q   <= s_axis_tuser[SlotW-1:0];
      s1_down_q   <= s_axis_tuser[SlotW];
      s1_stroke_q <= s_axis_tuser[SlotW+1 +: StatusW];
      s1_data_q   <= s_axis_tdata;
    end
  end

  assign s1_start_x    = s1_data_q[0 +: CoordW];
  assign s1_start_y    = s1_data_q[CoordW +: CoordW];
  assign s1_start_time = s1_data_q[2*CoordW +: TimeW];
  assign s1_cur_x      = s1_data_q[2*CoordW+TimeW +: CoordW];
  assign s1_cur_y      = s1_data_q[3*CoordW+TimeW +: CoordW];
  assign s1_cur_time   = s1_data_q[4*CoordW+TimeW +: TimeW];

  assign s1_adx = (s1_cur_x >= s1_start_x) ? s1_cur_x - s1_start_x : s1_start_x - s1_cur_x;
  assign s1_ady = (s1_cur_y >= s1_start_y) ? s1_cur_y - s1_start_y : s1_start_y - s1_cur_y;
  assign s1_dt  = s1_cur_time - s1_start_time;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_slot_q    <= s1_slot_q;
      s2_down_q    <= s1_down_q;
      s2_stroke_q  <= s1_stroke_q;
      s2_data_q    <= s1_data_q;
      s2_dx2_q     <= s1_adx * s1_adx;
      s2_dy2_q     <= s1_ady * s1_ady;
      s2_hold_ok_q <= s1_dt > TimeW'(min_hold_q);
    end
  end

  thgr_slot_store #(
    .SLOTS(SLOTS),
    .IdxW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_move),
    .rd_idx_i  (IdxW'(s1_slot_q)),
    .rd_state_o(cur_state),
    .wr_en_i   (s2_move),
    .wr_idx_i  (IdxW'(s2_slot_q)),
    .wr_state_i(nxt_state)
  );

  assign d2      = (SqW+1)'(s2_dx2_q) + (SqW+1)'(s2_dy2_q);
  assign too_far = d2 > (SqW+1)'(lim_q);
  assign stroke  = hold_state_e'(s2_stroke_q);

  always_comb begin
    nxt_state = cur_state;
    call      = 1'b0;
    unique case (cur_state)
      HOLD_NULL: begin
        if (stroke == HOLD_PROG) begin
          nxt_state = HOLD_PROG;
          call      = 1'b1;
        end
      end
      HOLD_PROG: begin
        if (stroke == HOLD_PROG) begin
          if (too_far) begin
            nxt_state = HOLD_FAIL;
          end
          call = 1'b1;
        end else if (stroke == HOLD_DONE) begin
          nxt_state = (s2_hold_ok_q && !too_far) ? HOLD_DONE : HOLD_FAIL;
          call      = 1'b1;
        end
      end
      HOLD_DONE, HOLD_FAIL: begin
        if (s2_down_q && (stroke == HOLD_PROG)) begin
          nxt_state = HOLD_PROG;
          call      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_user_q <= {call && notify_en_q, nxt_state, s2_slot_q};
      out_data_q <= s2_data_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  a_notify_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[UserW-1]) |-> notify_en_q)
    else $error("notify raised while notify is disabled");

  a_null_never_notifies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[SlotW +: StatusW] == HOLD_NULL))
      |-> !m_axis_tuser[UserW-1])
    else $error("null hold state reported with notify");

  a_result_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_ready) |=> m_axis_tvalid)
    else $error("evaluated request did not reach the output register");

endmodule
